[sv/tesd_pkg.sv]
// Package for the terminal escape sequence decoder.
// Holds the phase type, result kinds, byte constants and the result struct.
// It has no dependencies.
package tesd_pkg;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 16;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_BRACKET = 3'd2,
    PH_QUERY   = 3'd3,
    PH_KEYPAD  = 3'd4,
    PH_SS3     = 3'd5,
    PH_NUMBER  = 3'd6
  } phase_t;

  localparam logic [KIND_W-1:0] KIND_PLAIN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CONTROL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_KEY     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_KEYPAD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ESC     = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SS3     = 8'h8F;
  localparam logic [CHAR_W-1:0] CH_CSI     = 8'h9B;
  localparam logic [CHAR_W-1:0] CH_DEL     = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_BRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_QUERY   = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_UPPER_O = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic                emit;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
  } result_t;

endpackage

[sv/tesd_if.sv]
// Handshake interfaces for the decoder's byte requests and result requests.
// Widths come from tesd_pkg.
interface tesd_char_if;
  logic                          valid;
  logic                          ready;
  logic [tesd_pkg::CHAR_W-1:0]   char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface tesd_key_if;
  logic                          valid;
  logic                          ready;
  logic [tesd_pkg::KIND_W-1:0]   kind;
  logic [tesd_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

[sv/tesd_decode.sv]
// Sequence state and classification for one byte per step.
// Holds the phase and the decimal accumulator; uses tesd_pkg.
module tesd_decode #(
  parameter int NUMBER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [tesd_pkg::CHAR_W-1:0]  char_in,
  output tesd_pkg::result_t            result
);

  localparam int PROD_W = NUMBER_BITS + 4;

  tesd_pkg::phase_t         phase, phase_next;
  logic [NUMBER_BITS-1:0]   acc, acc_next;

  logic              is_ctrl, is_digit, is_upper, is_lower;
  logic [3:0]        digit;
  logic [PROD_W-1:0] acc_wide, prod;

  assign is_ctrl  = (char_in < tesd_pkg::CH_SPACE) || (char_in == tesd_pkg::CH_DEL);
  assign is_digit = (char_in >= tesd_pkg::CH_ZERO) && (char_in <= tesd_pkg::CH_NINE);
  assign is_upper = (char_in >= tesd_pkg::CH_UPPER_A) && (char_in <= tesd_pkg::CH_UPPER_Z);
  assign is_lower = (char_in >= tesd_pkg::CH_LOWER_A) && (char_in <= tesd_pkg::CH_LOWER_Z);
  assign digit    = char_in[3:0];

  // Times ten as two shifts and an add; the top four bits flag overflow.
  assign acc_wide = PROD_W'(acc);
  assign prod     = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(digit);

  always_comb begin
    phase_next   = phase;
    acc_next     = acc;
    result.emit  = 1'b0;
    result.kind  = tesd_pkg::KIND_PLAIN;
    result.value = tesd_pkg::VALUE_W'(char_in);
    case (phase)
      tesd_pkg::PH_ESC: begin
        if (is_ctrl) begin
          result.emit = 1'b1;
          result.kind = tesd_pkg::KIND_CONTROL;
        end else if (char_in == tesd_pkg::CH_BRACKET) begin
          phase_next = tesd_pkg::PH_BRACKET;
        end else if (char_in == tesd_pkg::CH_QUERY) begin
          phase_next = tesd_pkg::PH_QUERY;
        end else if (char_in == tesd_pkg::CH_UPPER_O) begin
          phase_next = tesd_pkg::PH_KEYPAD;
        end else begin
          result.emit = 1'b1;
          result.kind = tesd_pkg::KIND_KEY;
        end
      end
      tesd_pkg::PH_BRACKET: begin
        if (is_digit) begin
          acc_next   = NUMBER_BITS'(digit);
          phase_next = tesd_pkg::PH_NUMBER;
        end else begin
          result.emit = 1'b1;
          result.kind = tesd_pkg::KIND_KEY;
        end
      end
      tesd_pkg::PH_QUERY: begin
        result.emit = 1'b1;
        result.kind = tesd_pkg::KIND_KEYPAD;
      end
      tesd_pkg::PH_KEYPAD: begin
        result.emit = 1'b1;
        result.kind = is_upper ? tesd_pkg::KIND_KEY : tesd_pkg::KIND_KEYPAD;
      end
      tesd_pkg::PH_SS3: begin
        result.emit = 1'b1;
        result.kind = is_lower ? tesd_pkg::KIND_KEYPAD : tesd_pkg::KIND_KEY;
      end
      tesd_pkg::PH_NUMBER: begin
        if (is_digit) begin
          if (prod[PROD_W-1:NUMBER_BITS] != 4'd0) begin
            acc_next = {NUMBER_BITS{1'b1}};
          end else begin
            acc_next = prod[NUMBER_BITS-1:0];
          end
        end else begin
          result.emit  = 1'b1;
          result.kind  = tesd_pkg::KIND_NUMBER;
          result.value = tesd_pkg::VALUE_W'(acc);
        end
      end
      default: begin
        if (char_in == tesd_pkg::CH_ESC) begin
          phase_next = tesd_pkg::PH_ESC;
        end else if (char_in == tesd_pkg::CH_SS3) begin
          phase_next = tesd_pkg::PH_SS3;
        end else if (char_in == tesd_pkg::CH_CSI) begin
          phase_next = tesd_pkg::PH_BRACKET;
        end else begin
          result.emit = 1'b1;
        end
      end
    endcase
    if (result.emit) begin
      phase_next = tesd_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tesd_pkg::PH_IDLE;
      acc   <= '0;
    end else if (step) begin
      phase <= phase_next;
      acc   <= acc_next;
    end
  end

endmodule

[sv/terminal_escape_sequence_decoder.sv]
// Top level of the terminal escape sequence decoder.
// Uses tesd_pkg, the interfaces in tesd_if.sv and tesd_decode.
//
// The block takes one received terminal byte per request on chars and gives
// at most one classified result per byte on keys. A plain byte comes out as
// kind 0 right away; ESC, SS3 and CSI open a sequence whose bytes produce no
// result until the completing byte, which yields one result of kind 1 to 4.
// A decimal parameter after ESC [ or CSI is accumulated in NUMBER_BITS bits,
// saturating at all ones, and the byte that ends it is consumed and reported
// as kind 4 with the number (low 16 bits) as the value. A byte is captured
// in an input register, classified against the sequence state once its
// result, if any, has room, and its result is then loaded into the output
// register, from which it is offered on keys until it is taken.
// The input register, the decode step and the output register form a short
// pipeline that accepts one byte every cycle as long as the consumer takes
// results; a stalled output holds one result while one more byte waits in
// the input register. Bytes that produce no result never stall.
module terminal_escape_sequence_decoder #(
  parameter int NUMBER_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  tesd_char_if.sink   chars,
  tesd_key_if.source  keys
);

  // Input register: the byte waiting to be classified.
  logic                          stage_valid;
  logic [tesd_pkg::CHAR_W-1:0]   stage_char;

  // Output register: the result waiting to be taken.
  logic                          out_valid;
  logic [tesd_pkg::KIND_W-1:0]   out_kind;
  logic [tesd_pkg::VALUE_W-1:0]  out_value;

  tesd_pkg::result_t result;
  logic              advance;

  // The staged byte is classified whenever its result, if any, has room:
  // either the output register is empty or it is being emptied now.
  assign advance     = stage_valid && (!result.emit || !out_valid || keys.ready);
  assign chars.ready = !stage_valid || advance;

  tesd_decode #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .char_in (stage_char),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (chars.ready) begin
      stage_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      stage_char <= chars.char_in;
    end
  end

  // A result leaves when taken; a new one from the decoder replaces it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (keys.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_kind  <= result.kind;
      out_value <= result.value;
    end
  end

  assign keys.valid = out_valid;
  assign keys.kind  = out_kind;
  assign keys.value = out_value;

endmodule

[bench/testbench.sv]
// Self-checking testbench for the terminal escape sequence decoder.
// Depends on tesd_pkg, the handshake interfaces in tesd_if.sv and the decoder top level.
// Directed sequences come first, then random sequences under several idle and stall mixes.
module testbench;

  localparam int NUMBER_BITS = 16;
  // A correct run never goes this long without a request moving on either side.
  localparam int STALL_LIMIT = 4000;
  localparam logic [63:0] NUMBER_MAX = (64'd1 << NUMBER_BITS) - 64'd1;

  typedef logic [tesd_pkg::CHAR_W-1:0] char_t;

  typedef struct packed {
    logic [tesd_pkg::KIND_W-1:0]  kind;
    logic [tesd_pkg::VALUE_W-1:0] value;
  } key_t;

  logic clk = 1'b0;
  logic rst;

  tesd_char_if chars_if ();
  tesd_key_if  keys_if ();

  terminal_escape_sequence_decoder #(
    .NUMBER_BITS(NUMBER_BITS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .chars(chars_if),
    .keys (keys_if)
  );

  // Clock with a period of 20 time units.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Keys that the decoder still owes us, oldest first.
  key_t pending_keys[$];

  // Our own copy of the decoder's sequence state.
  tesd_pkg::phase_t seq_phase;
  logic [63:0]      seq_number;

  // Percentages of cycles in which the byte sender idles and the key consumer stalls.
  int idle_pct;
  int stall_pct;

  int bytes_sent;
  int keys_checked;
  int mismatches;
  int saturated_numbers;
  int kind_count [5];
  int idle_cycles;

  function automatic bit is_control(input char_t c);
    return (c < tesd_pkg::CH_SPACE) || (c == tesd_pkg::CH_DEL);
  endfunction

  function automatic bit is_digit(input char_t c);
    return (c >= tesd_pkg::CH_ZERO) && (c <= tesd_pkg::CH_NINE);
  endfunction

  // Advance the sequence state by one byte. Returns 1 when the byte completes a
  // key, which is then written to key.
  function automatic bit decode_byte(input char_t c, output key_t key);
    bit          emits;
    logic [63:0] acc;
    emits     = 1'b1;
    key.kind  = tesd_pkg::KIND_KEY;
    key.value = {{(tesd_pkg::VALUE_W-tesd_pkg::CHAR_W){1'b0}}, c};
    case (seq_phase)
      tesd_pkg::PH_ESC: begin
        if (is_control(c)) begin
          key.kind = tesd_pkg::KIND_CONTROL;
        end else if (c == tesd_pkg::CH_BRACKET) begin
          emits     = 1'b0;
          seq_phase = tesd_pkg::PH_BRACKET;
        end else if (c == tesd_pkg::CH_QUERY) begin
          emits     = 1'b0;
          seq_phase = tesd_pkg::PH_QUERY;
        end else if (c == tesd_pkg::CH_UPPER_O) begin
          emits     = 1'b0;
          seq_phase = tesd_pkg::PH_KEYPAD;
        end
      end
      tesd_pkg::PH_BRACKET: begin
        if (is_digit(c)) begin
          emits      = 1'b0;
          seq_number = 64'(c - tesd_pkg::CH_ZERO);
          seq_phase  = tesd_pkg::PH_NUMBER;
        end
      end
      tesd_pkg::PH_QUERY: begin
        key.kind = tesd_pkg::KIND_KEYPAD;
      end
      tesd_pkg::PH_KEYPAD: begin
        if (!(c >= tesd_pkg::CH_UPPER_A && c <= tesd_pkg::CH_UPPER_Z)) begin
          key.kind = tesd_pkg::KIND_KEYPAD;
        end
      end
      tesd_pkg::PH_SS3: begin
        if (c >= tesd_pkg::CH_LOWER_A && c <= tesd_pkg::CH_LOWER_Z) begin
          key.kind = tesd_pkg::KIND_KEYPAD;
        end
      end
      tesd_pkg::PH_NUMBER: begin
        if (is_digit(c)) begin
          emits      = 1'b0;
          acc        = seq_number * 64'd10 + 64'(c - tesd_pkg::CH_ZERO);
          seq_number = (acc > NUMBER_MAX) ? NUMBER_MAX : acc;
        end else begin
          // The terminating byte is swallowed; only the number is reported.
          key.kind  = tesd_pkg::KIND_NUMBER;
          key.value = seq_number[tesd_pkg::VALUE_W-1:0];
          if (seq_number == NUMBER_MAX) saturated_numbers++;
        end
      end
      default: begin
        key.kind = tesd_pkg::KIND_PLAIN;
        if (c == tesd_pkg::CH_ESC) begin
          emits     = 1'b0;
          seq_phase = tesd_pkg::PH_ESC;
        end else if (c == tesd_pkg::CH_SS3) begin
          emits     = 1'b0;
          seq_phase = tesd_pkg::PH_SS3;
        end else if (c == tesd_pkg::CH_CSI) begin
          emits     = 1'b0;
          seq_phase = tesd_pkg::PH_BRACKET;
        end
      end
    endcase
    if (emits) seq_phase = tesd_pkg::PH_IDLE;
    return emits;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one byte, with random idle cycles in front, and hold it until the
  // decoder takes the request. The expected key, if any, is queued on acceptance.
  task automatic send_byte(input char_t c);
    key_t key;
    while ($urandom_range(99) < idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid   <= 1'b1;
    chars_if.char_in <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    bytes_sent++;
    if (decode_byte(c, key)) pending_keys.push_back(key);
  endtask

  // Stop sending and let every owed key come out, then let the pipeline settle.
  task automatic wait_for_keys_drained;
    chars_if.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic char_t random_nondigit();
    char_t c;
    c = char_t'($urandom_range(255));
    while (is_digit(c)) c = char_t'($urandom_range(255));
    return c;
  endfunction

  // Either spelling of the bracket introducer: ESC [ or the single CSI byte.
  task automatic send_bracket_intro;
    if ($urandom_range(1) == 0) begin
      send_byte(tesd_pkg::CH_ESC);
      send_byte(tesd_pkg::CH_BRACKET);
    end else begin
      send_byte(tesd_pkg::CH_CSI);
    end
  endtask

  // One random sequence. Most are well formed with random content; the rest are
  // bare bytes and sequences cut short, whose leftovers run into the next one.
  task automatic send_random_sequence;
    int unsigned ndigits;
    char_t       c;
    case ($urandom_range(9))
      0, 1: begin
        c = char_t'($urandom_range(255));
        send_byte(c);
      end
      2: begin
        c = char_t'($urandom_range(255));
        send_byte(tesd_pkg::CH_ESC);
        send_byte(c);
      end
      3: begin
        send_bracket_intro();
        send_byte(random_nondigit());
      end
      4, 5: begin
        // Mostly short numbers; long ones can drive the accumulator into saturation.
        ndigits = ($urandom_range(3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        send_bracket_intro();
        repeat (ndigits) begin
          c = tesd_pkg::CH_ZERO + char_t'($urandom_range(9));
          send_byte(c);
        end
        send_byte(random_nondigit());
      end
      6: begin
        c = char_t'($urandom_range(255));
        send_byte(tesd_pkg::CH_ESC);
        send_byte(tesd_pkg::CH_QUERY);
        send_byte(c);
      end
      7: begin
        case ($urandom_range(2))
          0:       c = tesd_pkg::CH_UPPER_A + char_t'($urandom_range(25));
          1:       c = tesd_pkg::CH_LOWER_A + char_t'($urandom_range(25));
          default: c = char_t'($urandom_range(255));
        endcase
        send_byte(tesd_pkg::CH_ESC);
        send_byte(tesd_pkg::CH_UPPER_O);
        send_byte(c);
      end
      8: begin
        case ($urandom_range(2))
          0:       c = tesd_pkg::CH_LOWER_A + char_t'($urandom_range(25));
          1:       c = tesd_pkg::CH_UPPER_A + char_t'($urandom_range(25));
          default: c = char_t'($urandom_range(255));
        endcase
        send_byte(tesd_pkg::CH_SS3);
        send_byte(c);
      end
      default: begin
        // A lone introducer: the sequence is completed by whatever follows.
        case ($urandom_range(2))
          0:       send_byte(tesd_pkg::CH_ESC);
          1:       send_byte(tesd_pkg::CH_SS3);
          default: send_byte(tesd_pkg::CH_CSI);
        endcase
      end
    endcase
  endtask

  // Byte extremes pass straight through.
  task automatic test_plain_bytes;
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // ESC with a control byte, with a second ESC inside the sequence, with a
  // printable byte, and the ESC ? form.
  task automatic test_escape_keys;
    send_byte(tesd_pkg::CH_ESC);
    send_byte(tesd_pkg::CH_DEL);
    send_byte(tesd_pkg::CH_ESC);
    send_byte(tesd_pkg::CH_ESC);
    send_byte(tesd_pkg::CH_ESC);
    send_byte("x");
    send_byte(tesd_pkg::CH_ESC);
    send_byte(tesd_pkg::CH_QUERY);
    send_byte("a");
  endtask

  // Keypad forms: ESC O upper case, SS3 lower case, an introducer arriving
  // inside an SS3 sequence, and CSI with a plain final byte.
  task automatic test_keypad_keys;
    send_byte(tesd_pkg::CH_ESC);
    send_byte(tesd_pkg::CH_UPPER_O);
    send_byte("P");
    send_byte(tesd_pkg::CH_SS3);
    send_byte("a");
    send_byte(tesd_pkg::CH_SS3);
    send_byte(tesd_pkg::CH_CSI);
    send_byte(tesd_pkg::CH_CSI);
    send_byte("A");
  endtask

  // A number past the 16-bit limit must stick at all ones.
  task automatic test_saturated_number;
    send_byte(tesd_pkg::CH_CSI);
    send_byte("7");
    send_byte("0");
    send_byte("0");
    send_byte("0");
    send_byte("0");
    send_byte(";");
  endtask

  // Random traffic under one idle/stall mix. Now and then the sender holds off
  // until every owed key has come out.
  task automatic test_random_traffic(input int idle, input int stall, input int count);
    int target;
    idle_pct  = idle;
    stall_pct = stall;
    target    = bytes_sent + count;
    while (bytes_sent < target) begin
      send_random_sequence();
      if ($urandom_range(49) == 0) wait_for_keys_drained();
    end
    wait_for_keys_drained();
  endtask

  // The key consumer: takes results except in the stalled share of cycles.
  always @(posedge clk) begin
    if (rst) begin
      keys_if.ready <= 1'b0;
    end else begin
      keys_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted key is checked against the oldest owed one.
  always @(posedge clk) begin : check_keys
    key_t want;
    if (!rst && keys_if.valid && keys_if.ready) begin
      if (pending_keys.size() == 0) begin
        report_mismatch("key with none owed, kind", int'(keys_if.kind), -1);
      end else begin
        want = pending_keys.pop_front();
        if (keys_if.kind !== want.kind) begin
          report_mismatch("kind", int'(keys_if.kind), int'(want.kind));
        end
        if (keys_if.value !== want.value) begin
          report_mismatch("value", int'(keys_if.value), int'(want.value));
        end
      end
      keys_checked++;
      if (keys_if.kind < 5) kind_count[keys_if.kind]++;
    end
  end

  // Watchdog: ends the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (keys_if.valid && keys_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles, %0d keys owed",
               STALL_LIMIT, pending_keys.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    chars_if.valid    = 1'b0;
    chars_if.char_in  = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    bytes_sent        = 0;
    keys_checked      = 0;
    mismatches        = 0;
    saturated_numbers = 0;
    seq_phase         = tesd_pkg::PH_IDLE;
    seq_number        = '0;
    foreach (kind_count[i]) kind_count[i] = 0;

    // Synchronous reset held, then released at a clock edge.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sequences with both sides always ready.
    test_plain_bytes();
    test_escape_keys();
    test_keypad_keys();
    test_saturated_number();
    wait_for_keys_drained();

    // Random sequences: no idling, a slow sender, a slow consumer, then both a little.
    test_random_traffic(0, 0, 425);
    test_random_traffic(77, 0, 425);
    test_random_traffic(0, 77, 425);
    test_random_traffic(12, 12, 425);

    stall_pct = 0;
    wait_for_keys_drained();
    if (pending_keys.size() != 0) begin
      report_mismatch("keys never delivered", 0, pending_keys.size());
    end

    $display("Summary: %0d bytes sent, %0d keys checked, %0d saturated numbers",
             bytes_sent, keys_checked, saturated_numbers);
    $display("Keys by kind: plain %0d, control %0d, key %0d, keypad %0d, number %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
